// ===== rtl/block_bitmap_allocator_assert.svh =====
// assertion macros for the block bitmap allocator
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("block bitmap allocator check failed");
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("block bitmap allocator check failed");
`else
`define BBA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
// shared types and constants of the block bitmap allocator
package bba_pkg;

   localparam int BLOCK_W        = 12;
   localparam int COUNT_W        = 13;
   localparam int STATUS_W       = 2;
   localparam int NUM_BLOCKS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 2'd0,
      ST_OUT_OF_BLOCKS = 2'd1,
      ST_FREE_FREE     = 2'd2,
      ST_OUT_OF_RANGE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_CHK,
      S_RESP
   } state_type;

endpackage

// ===== rtl/block_bitmap_allocator.sv =====
// first-fit bitmap block allocator, top level with sequencer
//
//  channel  direction  signals                                   handshake
//  req      in         req_opcode, req_block_number              req_valid / req_ready
//  rsp      out        rsp_allocated_block, rsp_status           rsp_valid / rsp_ready
//  csr      in         csr_wr_data                               csr_wr_en, no wait
//
// allocate: one bitmap word per cycle through the word scanner; stops at the first word
//   with a free bit
// free: read word, check and write back, respond; out of range: straight to respond
// the bitmap memory ports are the limit: one word read or written per cycle
// reset is synchronous; the bitmap reads as all free through per-row valid bits
// req_ready is low from acceptance until the response transaction completes
module block_bitmap_allocator #(
   parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
   parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::BLOCK_W-1:0]   rsp_allocated_block,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_wr_en,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_wr_data
);

`include "block_bitmap_allocator_assert.svh"

   localparam int NUM_WORDS = NUM_BLOCKS / WORD_BITS;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BLK_W     = $clog2(NUM_BLOCKS);
   localparam int WADDR_W   = BLK_W - BIT_W;
   localparam int CW        = (bba_pkg::COUNT_W > BLK_W + 1) ? bba_pkg::COUNT_W : BLK_W + 1;

   bba_pkg::state_type  state_ff, state_in;
   bba_pkg::status_type status_ff, status_in;

   logic [bba_pkg::COUNT_W-1:0] blocks_in_use_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [WADDR_W:0]            words_ff, words_in;
   logic [WADDR_W:0]            scan_ptr_ff, scan_ptr_in;
   logic                        pend_ff, pend_in;
   logic [WADDR_W-1:0]          pend_word_ff, pend_word_in;
   logic [BLK_W-1:0]            blk_ff, blk_in;
   logic [bba_pkg::BLOCK_W-1:0] alloc_ff, alloc_in;

   logic [CW-1:0]        cfg_ext;
   logic [CW-1:0]        eff_count;
   logic [CW-1:0]        words_full;
   logic [CW-1:0]        req_blk_ext;
   logic                 req_free;
   logic                 req_out_of_range;
   logic                 issue_ok;
   logic                 found;
   logic [BIT_W-1:0]     hit_bit;
   logic                 scan_hit;
   logic                 scan_miss;
   logic [CW-1:0]        hit_ext;
   logic [BIT_W-1:0]     free_bit;
   logic [WADDR_W-1:0]   free_word;

   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= bba_pkg::COUNT_RESET;
      end else if (csr_wr_en) begin
         blocks_in_use_ff <= csr_wr_data;
      end
   end

   // count saturates at the capacity
   assign cfg_ext   = CW'(blocks_in_use_ff);
   assign eff_count = (cfg_ext > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : cfg_ext;
   assign words_full = (eff_count + CW'(WORD_BITS - 1)) >> BIT_W;

   assign req_blk_ext      = CW'(req_block_number);
   assign req_free         = bba_pkg::opcode_type'(req_opcode) == bba_pkg::OP_FREE;
   assign req_out_of_range = req_blk_ext >= eff_count;

   bba_bitmap #(
      .NUM_WORDS (NUM_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bba_find_free #(
      .WORD_BITS (WORD_BITS),
      .WADDR_W   (WADDR_W),
      .CNT_W     (CW)
   ) u_find_free (
      .word_data  (rd_data),
      .word_index (pend_word_ff),
      .count      (count_ff),
      .found      (found),
      .bit_index  (hit_bit)
   );

   assign issue_ok  = scan_ptr_ff < words_ff;
   assign scan_hit  = (state_ff == bba_pkg::S_SCAN) && pend_ff && found;
   assign scan_miss = (state_ff == bba_pkg::S_SCAN) && !pend_ff && !issue_ok;
   assign hit_ext   = CW'({pend_word_ff, hit_bit});
   assign free_bit  = blk_ff[BIT_W-1:0];
   assign free_word = blk_ff[BLK_W-1:BIT_W];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               if (!req_free) begin
                  state_in = bba_pkg::S_SCAN;
               end else if (req_out_of_range) begin
                  state_in = bba_pkg::S_RESP;
               end else begin
                  state_in = bba_pkg::S_FREE_RD;
               end
            end
         end
         bba_pkg::S_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = bba_pkg::S_RESP;
            end
         end
         bba_pkg::S_FREE_RD:  state_in = bba_pkg::S_FREE_CHK;
         bba_pkg::S_FREE_CHK: state_in = bba_pkg::S_RESP;
         bba_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      words_in     = words_ff;
      scan_ptr_in  = scan_ptr_ff;
      pend_in      = pend_ff;
      pend_word_in = pend_word_ff;
      blk_in       = blk_ff;
      alloc_in     = alloc_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      rd_addr      = scan_ptr_ff[WADDR_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_word_ff;
      wr_data      = rd_data | (WORD_BITS'(1) << hit_bit);
      unique case (state_ff)
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               count_in    = eff_count;
               words_in    = words_full[WADDR_W:0];
               scan_ptr_in = '0;
               pend_in     = 1'b0;
               blk_in      = req_blk_ext[BLK_W-1:0];
               alloc_in    = '0;
               status_in   = (req_free && req_out_of_range) ? bba_pkg::ST_OUT_OF_RANGE
                                                            : bba_pkg::ST_OK;
            end
         end
         bba_pkg::S_SCAN: begin
            // issue the next word while the previous one is examined
            if (issue_ok && !scan_hit) begin
               rd_en        = 1'b1;
               scan_ptr_in  = scan_ptr_ff + (WADDR_W+1)'(1);
               pend_in      = 1'b1;
               pend_word_in = scan_ptr_ff[WADDR_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (scan_hit) begin
               wr_en     = 1'b1;
               alloc_in  = hit_ext[bba_pkg::BLOCK_W-1:0];
               status_in = bba_pkg::ST_OK;
            end
            if (scan_miss) begin
               alloc_in  = '0;
               status_in = bba_pkg::ST_OUT_OF_BLOCKS;
            end
         end
         bba_pkg::S_FREE_RD: begin
            rd_en   = 1'b1;
            rd_addr = free_word;
         end
         bba_pkg::S_FREE_CHK: begin
            wr_addr = free_word;
            wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
            if (rd_data[free_bit]) begin
               wr_en     = 1'b1;
               status_in = bba_pkg::ST_OK;
            end else begin
               status_in = bba_pkg::ST_FREE_FREE;
            end
         end
         bba_pkg::S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      words_ff     <= words_in;
      scan_ptr_ff  <= scan_ptr_in;
      pend_word_ff <= pend_word_in;
      blk_ff       <= blk_in;
      alloc_ff     <= alloc_in;
      status_ff    <= status_in;
   end

   assign req_ready           = state_ff == bba_pkg::S_IDLE;
   assign rsp_valid           = state_ff == bba_pkg::S_RESP;
   assign rsp_allocated_block = alloc_ff;
   assign rsp_status          = status_ff;

   `BBA_ASSERT_SAME(a_req_rsp_excl, clock, reset, req_valid && req_ready, !rsp_valid)
   `BBA_ASSERT_SAME(a_fail_zero_block, clock, reset,
                    rsp_valid && rsp_status != bba_pkg::ST_OK, rsp_allocated_block == '0)
   `BBA_ASSERT_SAME(a_write_states, clock, reset, wr_en,
                    state_ff == bba_pkg::S_SCAN || state_ff == bba_pkg::S_FREE_CHK)
   `BBA_ASSERT_SAME(a_scan_bound, clock, reset, state_ff == bba_pkg::S_SCAN,
                    scan_ptr_ff <= words_ff)
   `BBA_ASSERT_NEXT(a_ready_after_rsp, clock, reset, rsp_valid && rsp_ready, req_ready)

endmodule

// ===== rtl/bba_bitmap.sv =====
// usage bitmap memory with per-row valid bits, one read and one write port
module bba_bitmap #(
   parameter int NUM_WORDS = bba_pkg::NUM_BLOCKS_DEF / bba_pkg::WORD_BITS_DEF,
   parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_WORDS)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]         rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_WORDS)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]         wr_data
);

   logic [WORD_BITS-1:0] mem_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic [WORD_BITS-1:0] rd_raw_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem_ff[rd_addr];
      end
   end

   // a row never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

// ===== rtl/bba_find_free.sv =====
// masks one bitmap word to the managed range and finds its lowest free bit
module bba_find_free #(
   parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
   parameter int WADDR_W   = 7,
   parameter int CNT_W     = 13
) (
   input  logic [WORD_BITS-1:0]         word_data,
   input  logic [WADDR_W-1:0]           word_index,
   input  logic [CNT_W-1:0]             count,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] bit_index
);

   localparam int BIT_W = $clog2(WORD_BITS);

   logic [CNT_W-1:0]     base;
   logic [CNT_W-1:0]     remaining;
   logic [WORD_BITS-1:0] in_range;
   logic [WORD_BITS-1:0] avail;

   assign base      = CNT_W'({word_index, BIT_W'(0)});
   assign remaining = count - base;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         in_range[i] = CNT_W'(i) < remaining;
      end
   end

   assign avail = ~word_data & in_range;
   assign found = |avail;

   // priority encoder, lowest set bit wins
   always_comb begin
      bit_index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            bit_index = BIT_W'(i);
         end
      end
   end

endmodule

// ===== tb/tb_block_bitmap_allocator.sv =====
// testbench for the first-fit block bitmap allocator
`timescale 1ns / 100ps

module tb_block_bitmap_allocator;

   localparam int MAX_COUNT      = bba_pkg::NUM_BLOCKS_DEF;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 140;
   localparam logic [bba_pkg::COUNT_W-1:0] COUNT_SATURATED = '1;

   typedef struct packed {
      logic [bba_pkg::BLOCK_W-1:0] block;
      bba_pkg::status_type         status;
   } outcome_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_opcode;
   logic [bba_pkg::BLOCK_W-1:0]  req_block_number;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [bba_pkg::BLOCK_W-1:0]  rsp_allocated_block;
   logic [bba_pkg::STATUS_W-1:0] rsp_status;
   logic                         csr_wr_en;
   logic [bba_pkg::COUNT_W-1:0]  csr_wr_data;

   // shadow of the allocator state
   bit [MAX_COUNT-1:0]           used_map;
   logic [bba_pkg::COUNT_W-1:0]  managed_count;

   outcome_type outcome_q[$];
   int          fail_count;
   bit          no_idle;
   int          long_hold_request;

   block_bitmap_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int effective_count();
      return (managed_count > MAX_COUNT) ? MAX_COUNT : int'(managed_count);
   endfunction

   // first-fit allocate or free against the shadow bitmap
   function automatic outcome_type apply_request(bba_pkg::opcode_type op,
                                                 logic [bba_pkg::BLOCK_W-1:0] blk);
      outcome_type res;
      int          eff;
      eff = effective_count();
      res.block = '0;
      if (op == bba_pkg::OP_ALLOC) begin
         res.status = bba_pkg::ST_OUT_OF_BLOCKS;
         for (int b = 0; b < eff; b++) begin
            if (!used_map[b]) begin
               used_map[b] = 1'b1;
               res.block = bba_pkg::BLOCK_W'(b);
               res.status = bba_pkg::ST_OK;
               break;
            end
         end
      end else if (int'(blk) >= eff) begin
         res.status = bba_pkg::ST_OUT_OF_RANGE;
      end else if (!used_map[blk]) begin
         res.status = bba_pkg::ST_FREE_FREE;
      end else begin
         used_map[blk] = 1'b0;
         res.status = bba_pkg::ST_OK;
      end
      return res;
   endfunction

   // a block in use below the count, so most frees succeed
   function automatic logic [bba_pkg::BLOCK_W-1:0] pick_used_block();
      int eff;
      int start;
      int b;
      eff = effective_count();
      if (eff > 0) begin
         start = $urandom_range(eff - 1);
         for (int i = 0; i < eff; i++) begin
            b = (start + i) % eff;
            if (used_map[b])
               return bba_pkg::BLOCK_W'(b);
         end
      end
      return bba_pkg::BLOCK_W'($urandom_range(MAX_COUNT - 1));
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t ns: %s", $realtime, msg);
   endtask

   task automatic send_req(bba_pkg::opcode_type op, logic [bba_pkg::BLOCK_W-1:0] blk);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_block_number <= blk;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      outcome_q.push_back(apply_request(op, blk));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(logic [bba_pkg::COUNT_W-1:0] value);
      wait_drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      managed_count = value;
   endtask

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            note_failure($sformatf("unexpected transaction: block %0d status %0d",
                                   rsp_allocated_block, rsp_status));
         end else begin
            want = outcome_q.pop_front();
            if (rsp_allocated_block !== want.block || rsp_status !== want.status)
               note_failure($sformatf({"mismatch: expected block %0d status %s, ",
                                       "got block %0d status %0d"},
                                      want.block, want.status.name(),
                                      rsp_allocated_block, rsp_status));
         end
      end
   end

   // receiver: random stalls, a quiet stretch and one long hold-off
   initial begin
      int seen;
      int hold_left;
      seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request != seen) begin
            seen = long_hold_request;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 21);
         end
      end
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // default count: first fit, reuse of a freed block, double free
   task automatic test_reset_state();
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_ALLOC, '1);
      send_req(bba_pkg::OP_ALLOC, 12'h5A5);
      send_req(bba_pkg::OP_FREE, 12'd1);
      send_req(bba_pkg::OP_FREE, 12'd1);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_FREE, 12'd4095);
      send_req(bba_pkg::OP_ALLOC, 12'hA5A);
   endtask

   // zero count, full bitmap, lowered count, saturated count
   task automatic test_count_limits();
      write_count('0);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_FREE, '0);
      write_count(13'd1);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_FREE, '0);
      send_req(bba_pkg::OP_ALLOC, '0);
      write_count(13'd6);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_FREE, 12'd5);
      write_count(13'd3);
      send_req(bba_pkg::OP_FREE, 12'd4);
      send_req(bba_pkg::OP_FREE, 12'd5);
      send_req(bba_pkg::OP_ALLOC, '0);
      write_count(COUNT_SATURATED);
      send_req(bba_pkg::OP_ALLOC, '0);
      send_req(bba_pkg::OP_FREE, 12'd4095);
      send_req(bba_pkg::OP_ALLOC, '0);
   endtask

   task automatic test_random_traffic();
      int                          items;
      int                          r;
      logic [bba_pkg::COUNT_W-1:0] count;
      for (int p = 0; p < 15; p++) begin
         items = 108;
         case (p % 7)
            0: count = bba_pkg::COUNT_W'($urandom_range(64, 1));
            1: count = bba_pkg::COUNT_W'($urandom_range(16, 1));
            2: count = bba_pkg::COUNT_RESET;
            3: count = COUNT_SATURATED;
            4: begin
               count = '0;
               items = 20;
            end
            5: count = bba_pkg::COUNT_W'($urandom_range(300, 1));
            default: count = bba_pkg::COUNT_W'($urandom);
         endcase
         write_count(count);
         no_idle = (p == 5);
         for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 50)
               send_req(bba_pkg::OP_ALLOC, bba_pkg::BLOCK_W'($urandom));
            else if (r < 85)
               send_req(bba_pkg::OP_FREE, pick_used_block());
            else
               send_req(bba_pkg::OP_FREE, bba_pkg::BLOCK_W'($urandom));
         end
         no_idle = 1'b0;
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_output_stall();
      write_count(13'd40);
      long_hold_request++;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 2)
            send_req(bba_pkg::OP_FREE, pick_used_block());
         else
            send_req(bba_pkg::OP_ALLOC, bba_pkg::BLOCK_W'($urandom));
      end
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = bba_pkg::OP_ALLOC;
      req_block_number  = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      fail_count        = 0;
      no_idle           = 1'b0;
      long_hold_request = 0;
      used_map          = '0;
      managed_count     = bba_pkg::COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_count_limits();
      test_random_traffic();
      test_output_stall();

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         note_failure($sformatf("%0d transactions never answered", outcome_q.size()));
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
